>>> rtl/bvp_pkg.sv
package bvp_pkg;

  // Table size and field widths.
  localparam int TABLE_POINTS = 21;
  localparam int SEGS         = TABLE_POINTS - 1;
  localparam int MV_W         = 16;
  localparam int PCT_W        = 7;
  localparam int SEG_W        = $clog2(SEGS);
  localparam int PROD_W       = MV_W + PCT_W;
  localparam int RECIP_SH     = 24;
  localparam int RECIP_W      = RECIP_SH + 1;
  localparam int QUEUE_DEPTH  = 2;

  typedef logic [MV_W-1:0]    mv_t;
  typedef logic [PCT_W-1:0]   pct_t;
  typedef logic [SEG_W-1:0]   seg_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [RECIP_W-1:0] recip_t;

  // Discharge curve of a four-cell pack, strictly descending.
  localparam mv_t LUT_MV [TABLE_POINTS] = '{
    16'd16800, 16'd16600, 16'd16450, 16'd16330, 16'd16090, 16'd15930, 16'd15810,
    16'd15660, 16'd15500, 16'd15420, 16'd15340, 16'd15260, 16'd15180, 16'd15140,
    16'd15060, 16'd14990, 16'd14910, 16'd14830, 16'd14750, 16'd14430, 16'd13090
  };

  localparam pct_t LUT_PCT [TABLE_POINTS] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
    7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
    7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
  };

  localparam mv_t SEG_SPAN [SEGS] = '{
    LUT_MV[0]  - LUT_MV[1],  LUT_MV[1]  - LUT_MV[2],  LUT_MV[2]  - LUT_MV[3],
    LUT_MV[3]  - LUT_MV[4],  LUT_MV[4]  - LUT_MV[5],  LUT_MV[5]  - LUT_MV[6],
    LUT_MV[6]  - LUT_MV[7],  LUT_MV[7]  - LUT_MV[8],  LUT_MV[8]  - LUT_MV[9],
    LUT_MV[9]  - LUT_MV[10], LUT_MV[10] - LUT_MV[11], LUT_MV[11] - LUT_MV[12],
    LUT_MV[12] - LUT_MV[13], LUT_MV[13] - LUT_MV[14], LUT_MV[14] - LUT_MV[15],
    LUT_MV[15] - LUT_MV[16], LUT_MV[16] - LUT_MV[17], LUT_MV[17] - LUT_MV[18],
    LUT_MV[18] - LUT_MV[19], LUT_MV[19] - LUT_MV[20]
  };

  localparam pct_t SEG_DPCT [SEGS] = '{
    LUT_PCT[0]  - LUT_PCT[1],  LUT_PCT[1]  - LUT_PCT[2],  LUT_PCT[2]  - LUT_PCT[3],
    LUT_PCT[3]  - LUT_PCT[4],  LUT_PCT[4]  - LUT_PCT[5],  LUT_PCT[5]  - LUT_PCT[6],
    LUT_PCT[6]  - LUT_PCT[7],  LUT_PCT[7]  - LUT_PCT[8],  LUT_PCT[8]  - LUT_PCT[9],
    LUT_PCT[9]  - LUT_PCT[10], LUT_PCT[10] - LUT_PCT[11], LUT_PCT[11] - LUT_PCT[12],
    LUT_PCT[12] - LUT_PCT[13], LUT_PCT[13] - LUT_PCT[14], LUT_PCT[14] - LUT_PCT[15],
    LUT_PCT[15] - LUT_PCT[16], LUT_PCT[16] - LUT_PCT[17], LUT_PCT[17] - LUT_PCT[18],
    LUT_PCT[18] - LUT_PCT[19], LUT_PCT[19] - LUT_PCT[20]
  };

  // Reciprocal of each segment span, scaled by two to the power RECIP_SH.
  localparam recip_t SEG_RECIP [SEGS] = '{
    RECIP_W'((2**RECIP_SH) / SEG_SPAN[0]),  RECIP_W'((2**RECIP_SH) / SEG_SPAN[1]),
    RECIP_W'((2**RECIP_SH) / SEG_SPAN[2]),  RECIP_W'((2**RECIP_SH) / SEG_SPAN[3]),
    RECIP_W'((2**RECIP_SH) / SEG_SPAN[4]),  RECIP_W'((2**RECIP_SH) / SEG_SPAN[5]),
    RECIP_W'((2**RECIP_SH) / SEG_SPAN[6]),  RECIP_W'((2**RECIP_SH) / SEG_SPAN[7]),
    RECIP_W'((2**RECIP_SH) / SEG_SPAN[8]),  RECIP_W'((2**RECIP_SH) / SEG_SPAN[9]),
    RECIP_W'((2**RECIP_SH) / SEG_SPAN[10]), RECIP_W'((2**RECIP_SH) / SEG_SPAN[11]),
    RECIP_W'((2**RECIP_SH) / SEG_SPAN[12]), RECIP_W'((2**RECIP_SH) / SEG_SPAN[13]),
    RECIP_W'((2**RECIP_SH) / SEG_SPAN[14]), RECIP_W'((2**RECIP_SH) / SEG_SPAN[15]),
    RECIP_W'((2**RECIP_SH) / SEG_SPAN[16]), RECIP_W'((2**RECIP_SH) / SEG_SPAN[17]),
    RECIP_W'((2**RECIP_SH) / SEG_SPAN[18]), RECIP_W'((2**RECIP_SH) / SEG_SPAN[19])
  };

  localparam pct_t SEG_LO_PCT [SEGS] = '{
    LUT_PCT[1],  LUT_PCT[2],  LUT_PCT[3],  LUT_PCT[4],  LUT_PCT[5],
    LUT_PCT[6],  LUT_PCT[7],  LUT_PCT[8],  LUT_PCT[9],  LUT_PCT[10],
    LUT_PCT[11], LUT_PCT[12], LUT_PCT[13], LUT_PCT[14], LUT_PCT[15],
    LUT_PCT[16], LUT_PCT[17], LUT_PCT[18], LUT_PCT[19], LUT_PCT[20]
  };

  // Classified sample as it leaves the front end.
  typedef struct packed {
    logic sat_hi;
    logic sat_lo;
    seg_t seg;
    mv_t  dmv;
  } fword_t;

  // Word carried through the arithmetic stages of the back end.
  typedef struct packed {
    logic  sat_hi;
    logic  sat_lo;
    seg_t  seg;
    prod_t num;
    pct_t  q0;
  } bword_t;

endpackage

>>> rtl/bvp_front.sv
module bvp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bvp_pkg::mv_t        voltage_mv,
  output logic                out_valid,
  input  logic                out_ready,
  output bvp_pkg::fword_t     out_word
);

  bvp_pkg::fword_t word_next;
  bvp_pkg::mv_t    lo_mv;
  bvp_pkg::seg_t   seg;

  // The table is strictly descending, so at most one segment matches.
  always_comb begin
    lo_mv = '0;
    seg   = '0;
    for (int j = 0; j < bvp_pkg::SEGS; j++) begin
      if (voltage_mv <= bvp_pkg::LUT_MV[j] && voltage_mv > bvp_pkg::LUT_MV[j+1]) begin
        lo_mv = lo_mv | bvp_pkg::LUT_MV[j+1];
        seg   = seg | bvp_pkg::seg_t'(j);
      end
    end
    word_next.sat_hi = voltage_mv >= bvp_pkg::LUT_MV[0];
    word_next.sat_lo = voltage_mv <= bvp_pkg::LUT_MV[bvp_pkg::TABLE_POINTS-1];
    word_next.seg    = seg;
    word_next.dmv    = voltage_mv - lo_mv;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_word <= word_next;
    end
  end

`ifndef ASSERT_OFF
  // A word that is not saturated must lie above the low point of its segment, at most at its top.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_word.sat_hi && !out_word.sat_lo)
      |-> (out_word.dmv != '0 && out_word.dmv <= bvp_pkg::SEG_SPAN[out_word.seg]))
    else $error("front: sample offset outside its segment");
`endif

endmodule

>>> rtl/bvp_queue.sv
module bvp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bvp_pkg::fword_t     in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output bvp_pkg::fword_t     out_word
);

  localparam int PTR_W = $clog2(bvp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(bvp_pkg::QUEUE_DEPTH + 1);

  bvp_pkg::fword_t   mem [bvp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign in_ready  = count != CNT_W'(bvp_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_word  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(bvp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(bvp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_word;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(bvp_pkg::QUEUE_DEPTH))
    else $error("queue: fill count beyond depth");

  // Pointers stay apart by the fill count.
  assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CNT_W'(bvp_pkg::QUEUE_DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue: pointers disagree with fill count");
`endif

endmodule

>>> rtl/bvp_back.sv
module bvp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bvp_pkg::fword_t     in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output bvp_pkg::pct_t       charge_percent
);

  logic            v1, v2, v3;
  logic            rdy1, rdy2, rdy3, rdy4;
  bvp_pkg::bword_t s1, s2, s3;
  bvp_pkg::bword_t s1_next, s2_next, s3_next;
  bvp_pkg::pct_t   pct_next;
  logic [bvp_pkg::PROD_W+bvp_pkg::RECIP_W-1:0] scaled;
  bvp_pkg::prod_t  back_prod;
  bvp_pkg::pct_t   q;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    // Stage 1: numerator is the offset times the percent step of the segment.
    s1_next        = '0;
    s1_next.sat_hi = in_word.sat_hi;
    s1_next.sat_lo = in_word.sat_lo;
    s1_next.seg    = in_word.seg;
    s1_next.num    = in_word.dmv * bvp_pkg::SEG_DPCT[in_word.seg];

    // Stage 2: estimate the quotient through the segment reciprocal. The
    // estimate is never high and at most one low.
    scaled      = s1.num * bvp_pkg::SEG_RECIP[s1.seg];
    s2_next     = s1;
    s2_next.q0  = scaled[bvp_pkg::RECIP_SH +: bvp_pkg::PCT_W];

    // Stage 3: remainder of the estimate replaces the numerator.
    back_prod   = s2.q0 * bvp_pkg::SEG_SPAN[s2.seg];
    s3_next     = s2;
    s3_next.num = s2.num - back_prod;

    // Stage 4: one correction step, then add the lower point of the segment.
    q = s3.q0 + {{(bvp_pkg::PCT_W-1){1'b0}},
                 s3.num >= bvp_pkg::prod_t'(bvp_pkg::SEG_SPAN[s3.seg])};
    priority if (s3.sat_hi) begin
      pct_next = bvp_pkg::LUT_PCT[0];
    end else if (s3.sat_lo) begin
      pct_next = bvp_pkg::LUT_PCT[bvp_pkg::TABLE_POINTS-1];
    end else begin
      pct_next = bvp_pkg::SEG_LO_PCT[s3.seg] + q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1 <= s1_next;
    if (rdy2 && v1) s2 <= s2_next;
    if (rdy3 && v2) s3 <= s3_next;
    if (rdy4 && v3) charge_percent <= pct_next;
  end

`ifndef ASSERT_OFF
  // The reciprocal estimate may never exceed the percent step of its segment.
  assert property (@(posedge clk) disable iff (rst)
    (v2 && !s2.sat_hi && !s2.sat_lo) |-> (s2.q0 <= bvp_pkg::SEG_DPCT[s2.seg]))
    else $error("back: quotient estimate too large");

  // A single correction step must be enough.
  assert property (@(posedge clk) disable iff (rst)
    (v3 && !s3.sat_hi && !s3.sat_lo)
      |-> (s3.num < {bvp_pkg::prod_t'(bvp_pkg::SEG_SPAN[s3.seg]), 1'b0}))
    else $error("back: remainder needs more than one correction");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (charge_percent <= bvp_pkg::LUT_PCT[0]))
    else $error("back: percentage above full charge");
`endif

endmodule

>>> rtl/battery_voltage_to_percent.sv
// Battery voltage to charge percentage.
// The input channel (in_valid, in_ready, voltage_mv) takes one pack voltage
// sample in millivolts per word. The output channel (out_valid, out_ready,
// charge_percent) returns one whole-percent state of charge per sample, in
// order, read off a fixed 21-point discharge curve by linear interpolation
// and saturated to 100 at the top and 0 at the bottom of the curve.
// A front end registers each sample and finds its segment; a two-word queue
// hands it to a back end of four stages that multiplies by the percent step,
// divides by the segment span through a stored reciprocal, corrects once and
// registers the result.
// Throughput is one word per cycle when nothing stalls, set by the back-end
// pipeline, whose first three stages each hold one multiplier.
// When the receiver holds out_ready low, the result stays in the output
// register, the stages behind it fill, then the queue, and in_ready falls only
// once every stage is full. Synchronous reset empties all stages and the
// queue; no word is in flight after reset.
module battery_voltage_to_percent (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bvp_pkg::mv_t        voltage_mv,
  output logic                out_valid,
  input  logic                out_ready,
  output bvp_pkg::pct_t       charge_percent
);

  logic            f_valid, f_ready;
  bvp_pkg::fword_t f_word;
  logic            q_valid, q_ready;
  bvp_pkg::fword_t q_word;

  bvp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .voltage_mv (voltage_mv),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_word   (f_word)
  );

  bvp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_word   (f_word),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_word  (q_word)
  );

  bvp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (q_valid),
    .in_ready       (q_ready),
    .in_word        (q_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .charge_percent (charge_percent)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Discharge curve of the pack: millivolts at each point and the charge there.
  localparam int unsigned CURVE_MV [bvp_pkg::TABLE_POINTS] = '{
    16800, 16600, 16450, 16330, 16090, 15930, 15810,
    15660, 15500, 15420, 15340, 15260, 15180, 15140,
    15060, 14990, 14910, 14830, 14750, 14430, 13090
  };
  localparam int unsigned CURVE_PCT [bvp_pkg::TABLE_POINTS] = '{
    100, 95, 90, 85, 80, 75, 70,
    65,  60, 55, 50, 45, 40, 35,
    30,  25, 20, 15, 10, 5,  0
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  bvp_pkg::mv_t   voltage_mv = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  bvp_pkg::pct_t  charge_percent;

  bvp_pkg::pct_t expected_pct [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  bit            sender_gaps = 1'b0;
  bit            receiver_stalls = 1'b0;
  int unsigned   long_hold_cycles = 0;

  battery_voltage_to_percent dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .voltage_mv     (voltage_mv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .charge_percent (charge_percent)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bvp_pkg::pct_t predict_percent(input bvp_pkg::mv_t mv);
    int unsigned sample;
    int unsigned hi_mv;
    int unsigned lo_mv;
    sample = mv;
    if (sample >= CURVE_MV[0]) return bvp_pkg::pct_t'(CURVE_PCT[0]);
    if (sample <= CURVE_MV[bvp_pkg::TABLE_POINTS-1])
      return bvp_pkg::pct_t'(CURVE_PCT[bvp_pkg::TABLE_POINTS-1]);
    for (int k = 0; k < bvp_pkg::TABLE_POINTS - 1; k++) begin
      hi_mv = CURVE_MV[k];
      lo_mv = CURVE_MV[k+1];
      if (sample <= hi_mv && sample > lo_mv) begin
        return bvp_pkg::pct_t'(CURVE_PCT[k+1] +
                               ((sample - lo_mv) * (CURVE_PCT[k] - CURVE_PCT[k+1])) /
                               (hi_mv - lo_mv));
      end
    end
    return '0;
  endfunction

  // Mostly samples on the curve, some hugging the table points, the rest anywhere.
  function automatic bvp_pkg::mv_t pick_sample();
    int unsigned sel;
    int unsigned idx;
    sel = $urandom_range(0, 99);
    if (sel < 60) return bvp_pkg::mv_t'($urandom_range(13000, 16900));
    if (sel < 80) begin
      idx = $urandom_range(0, bvp_pkg::TABLE_POINTS - 1);
      return bvp_pkg::mv_t'(CURVE_MV[idx] + $urandom_range(0, 6) - 3);
    end
    return bvp_pkg::mv_t'($urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Offers one word and returns at the edge that accepts it, leaving in_valid high.
  task automatic send_sample(input bvp_pkg::mv_t mv);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    voltage_mv <= mv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Expectations are queued at the accepting edge and results checked in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) expected_pct.push_back(predict_percent(voltage_mv));
      if (out_valid && out_ready) begin
        if (expected_pct.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", charge_percent));
        end else begin
          if (charge_percent !== expected_pct[0])
            report_mismatch($sformatf("charge_percent %0d, expected %0d",
                                      charge_percent, expected_pct[0]));
          void'(expected_pct.pop_front());
        end
      end
    end
  end

  // Receiver: random stalls when enabled, and a long hold-off on request.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (long_hold_cycles) @(posedge clk);
        long_hold_cycles = 0;
      end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Saturation on both sides, the ends of the field and every inner table point.
  task automatic test_curve_points();
    send_sample(16'd0);
    send_sample(16'd65535);
    send_sample(16'd16800);
    send_sample(16'd16801);
    send_sample(16'd13090);
    send_sample(16'd13091);
    for (int k = 1; k < bvp_pkg::TABLE_POINTS - 1; k++)
      send_sample(bvp_pkg::mv_t'(CURVE_MV[k]));
  endtask

  task automatic test_random_samples(input int unsigned count);
    repeat (count) send_sample(pick_sample());
  endtask

  // The receiver holds off long enough for the pipeline and queue to fill,
  // so the sender must see in_ready fall while it keeps offering words.
  task automatic test_output_backpressure();
    sender_gaps = 1'b0;
    long_hold_cycles = 150;
    repeat (40) send_sample(pick_sample());
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (expected_pct.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_pct.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_curve_points();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    test_random_samples(880);
    test_output_backpressure();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    test_random_samples(260);
    finish_run();
  end

endmodule
